### rtl/core/rde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_pkg
// Shared types and constants for the reversible deque engine.
// ----------------------------------------------------------------------------
package rde_pkg;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  typedef logic [AW-1:0] ptr_t;
  typedef logic [CW-1:0] cnt_t;
  typedef logic [CW:0]   sum_t;
  typedef logic [15:0]   elem_t;

  localparam sum_t DEPTH_S = sum_t'(DEPTH);
  localparam cnt_t DEPTH_C = cnt_t'(DEPTH);
  localparam ptr_t LAST_P  = ptr_t'(DEPTH - 1);

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_REV    = 3'd2,
    OP_DELETE = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_DONE  = 3'd0,
    ST_ERROR = 3'd1,
    ST_VALUE = 3'd2,
    ST_EMPTY = 3'd3,
    ST_FULL  = 3'd4
  } status_e;

endpackage

### rtl/core/reversible_deque_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reversible_deque_engine_unit
// Ring-buffer deque with a direction bit, streaming command in, status out.
// ----------------------------------------------------------------------------
// One command beat is taken per cycle unless the result side stalls; each
// gives exactly one result beat via a pending and an output register. Head,
// fill count, direction and error flag live in flip-flops and are updated at
// acceptance; the elements live in a single-port-per-direction synchronous RAM
// of 1024 x 16, written by append and read by read-out, with registered read
// data. Every command touches at most one entry, so throughput is one beat per
// cycle while the result side keeps up. RAM contents are not cleared.
// ----------------------------------------------------------------------------
module reversible_deque_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [2:0] opcode, [18:3] value, rest zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [2:0] status, [18:3] out_value, rest zero
  output logic        m_axis_tlast_o    // last
);

  rde_pkg::elem_t mem [rde_pkg::DEPTH];
  rde_pkg::elem_t rdata_q;

  rde_pkg::ptr_t head_q, head_d;
  rde_pkg::cnt_t fill_q, fill_d;
  logic          rev_q, rev_d;
  logic          err_q, err_d;

  logic              p_valid_q, p_pop_q, p_last_q;
  rde_pkg::status_e  p_status_q;
  logic              o_valid_q, o_last_q;
  rde_pkg::status_e  o_status_q;
  rde_pkg::elem_t    o_value_q;

  logic              adv, acc;
  rde_pkg::op_e      op;
  rde_pkg::elem_t    val;
  logic              we, re, pop, last;
  rde_pkg::ptr_t     waddr, raddr;
  rde_pkg::status_e  status;

  rde_pkg::sum_t     sum_back, sum_tail;
  rde_pkg::sum_t     wrap_back, wrap_tail;
  rde_pkg::ptr_t     back_p, tail_p, head_inc, head_dec;

  assign adv = !o_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !p_valid_q || adv;
  assign acc = s_axis_tvalid_i && s_axis_tready_o;

  assign op  = rde_pkg::op_e'(s_axis_tdata_i[2:0]);
  assign val = s_axis_tdata_i[18:3];

  // physical positions derived from head and fill
  assign sum_back  = rde_pkg::sum_t'(head_q) + rde_pkg::sum_t'(fill_q);
  assign sum_tail  = sum_back - rde_pkg::sum_t'(1);
  assign wrap_back = (sum_back >= rde_pkg::DEPTH_S) ? sum_back - rde_pkg::DEPTH_S : sum_back;
  assign wrap_tail = (sum_tail >= rde_pkg::DEPTH_S) ? sum_tail - rde_pkg::DEPTH_S : sum_tail;
  assign back_p    = wrap_back[rde_pkg::AW-1:0];
  assign tail_p    = wrap_tail[rde_pkg::AW-1:0];
  assign head_inc  = (head_q == rde_pkg::LAST_P) ? '0 : head_q + rde_pkg::ptr_t'(1);
  assign head_dec  = (head_q == '0) ? rde_pkg::LAST_P : head_q - rde_pkg::ptr_t'(1);

  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    rev_d  = rev_q;
    err_d  = err_q;
    we     = 1'b0;
    re     = 1'b0;
    pop    = 1'b0;
    last   = 1'b0;
    waddr  = back_p;
    raddr  = head_q;
    status = rde_pkg::ST_DONE;
    if (acc) begin
      case (op)
        rde_pkg::OP_CLEAR: begin
          head_d = '0;
          fill_d = '0;
          rev_d  = 1'b0;
          err_d  = 1'b0;
        end
        rde_pkg::OP_APPEND: begin
          if (fill_q == rde_pkg::DEPTH_C) begin
            status = rde_pkg::ST_FULL;
          end else begin
            we     = 1'b1;
            fill_d = fill_q + rde_pkg::cnt_t'(1);
            if (rev_q) begin
              head_d = head_dec;
              waddr  = head_dec;
            end
          end
        end
        rde_pkg::OP_REV: begin
          if (err_q) status = rde_pkg::ST_ERROR;
          else       rev_d  = !rev_q;
        end
        rde_pkg::OP_DELETE, rde_pkg::OP_READ: begin
          if (err_q) begin
            status = rde_pkg::ST_ERROR;
          end else if (fill_q == '0) begin
            if (op == rde_pkg::OP_DELETE) begin
              err_d  = 1'b1;
              status = rde_pkg::ST_ERROR;
            end else begin
              status = rde_pkg::ST_EMPTY;
            end
          end else begin
            fill_d = fill_q - rde_pkg::cnt_t'(1);
            if (rev_q) raddr  = tail_p;
            else       head_d = head_inc;
            if (op == rde_pkg::OP_READ) begin
              re     = 1'b1;
              pop    = 1'b1;
              last   = (fill_q == rde_pkg::cnt_t'(1));
              status = rde_pkg::ST_VALUE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= val;
    if (re) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      fill_q    <= '0;
      rev_q     <= 1'b0;
      err_q     <= 1'b0;
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
      rev_q  <= rev_d;
      err_q  <= err_d;
      if (s_axis_tready_o) p_valid_q <= acc;
      if (adv)             o_valid_q <= p_valid_q;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (acc) begin
      p_pop_q    <= pop;
      p_last_q   <= last;
      p_status_q <= status;
    end
    if (adv && p_valid_q) begin
      o_status_q <= p_status_q;
      o_last_q   <= p_last_q;
      o_value_q  <= p_pop_q ? rdata_q : '0;
    end
  end

  assign m_axis_tvalid_o = o_valid_q;
  assign m_axis_tdata_o  = {5'b0, o_value_q, o_status_q};
  assign m_axis_tlast_o  = o_last_q;

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the reversible deque engine.
// ----------------------------------------------------------------------------
// Command beats go in through a plain driver task. A shadow deque, kept in a
// small class, follows every accepted command and queues the status beat it
// should give; each result beat is compared with the oldest queued one. A
// directed opening walks the corner cases, including the error lock-out and
// unused opcodes. Random traffic follows under three idle patterns.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    rde_pkg::status_e status;
    rde_pkg::elem_t   value;
    logic             last;
  } reply_t;

  class deque_tracker;
    rde_pkg::elem_t ring [rde_pkg::DEPTH];
    rde_pkg::ptr_t  head;
    rde_pkg::cnt_t  fill;
    bit             rev;
    bit             err;
    reply_t         due_replies [$];
    int unsigned    failures;

    function new();
      head     = '0;
      fill     = '0;
      rev      = 1'b0;
      err      = 1'b0;
      failures = 0;
    endfunction

    function int unsigned outstanding();
      return due_replies.size();
    endfunction

    function rde_pkg::elem_t take_front_elem();
      rde_pkg::elem_t v;
      if (!rev) begin
        v    = ring[head];
        head = head + 1'b1;
      end else begin
        v = ring[rde_pkg::ptr_t'(head + fill - 1'b1)];
      end
      fill = fill - 1'b1;
      return v;
    endfunction

    function void note_command(logic [2:0] op, rde_pkg::elem_t val);
      reply_t r;
      r = '{status: rde_pkg::ST_DONE, value: '0, last: 1'b0};
      case (op)
        rde_pkg::OP_CLEAR: begin
          head = '0;
          fill = '0;
          rev  = 1'b0;
          err  = 1'b0;
        end
        rde_pkg::OP_APPEND: begin
          if (fill == rde_pkg::DEPTH_C) begin
            r.status = rde_pkg::ST_FULL;
          end else if (!rev) begin
            ring[rde_pkg::ptr_t'(head + fill)] = val;
            fill = fill + 1'b1;
          end else begin
            head       = head - 1'b1;
            ring[head] = val;
            fill       = fill + 1'b1;
          end
        end
        rde_pkg::OP_REV: begin
          if (err) r.status = rde_pkg::ST_ERROR;
          else rev = !rev;
        end
        rde_pkg::OP_DELETE: begin
          if (err) begin
            r.status = rde_pkg::ST_ERROR;
          end else if (fill == 0) begin
            err      = 1'b1;
            r.status = rde_pkg::ST_ERROR;
          end else begin
            void'(take_front_elem());
          end
        end
        rde_pkg::OP_READ: begin
          if (err) begin
            r.status = rde_pkg::ST_ERROR;
          end else if (fill == 0) begin
            r.status = rde_pkg::ST_EMPTY;
          end else begin
            r.value  = take_front_elem();
            r.status = rde_pkg::ST_VALUE;
            r.last   = (fill == 0);
          end
        end
        default: begin
        end
      endcase
      due_replies = {due_replies, r};
    endfunction

    function void check_result(logic [2:0] st, rde_pkg::elem_t v, logic lst);
      reply_t exp;
      if (due_replies.size() == 0) begin
        $display("%0t: unexpected beat: status %0d value %0d last %0b",
                 $time, st, $signed(v), lst);
        failures++;
        return;
      end
      exp = due_replies[0];
      due_replies.delete(0);
      if (st !== exp.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp.status, st);
        failures++;
      end
      if (v !== exp.value) begin
        $display("%0t: out_value expected %0d actual %0d",
                 $time, $signed(exp.value), $signed(v));
        failures++;
      end
      if (lst !== exp.last) begin
        $display("%0t: last expected %0b actual %0b", $time, exp.last, lst);
        failures++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        cmd_tvalid = 1'b0;
  logic [23:0] cmd_tdata = '0;
  logic        cmd_tready;
  logic        res_tvalid;
  logic        res_tready = 1'b0;
  logic [23:0] res_tdata;
  logic        res_tlast;

  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  deque_tracker tracker;

  reversible_deque_engine_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (cmd_tvalid),
    .s_axis_tready_o (cmd_tready),
    .s_axis_tdata_i  (cmd_tdata),
    .m_axis_tvalid_o (res_tvalid),
    .m_axis_tready_i (res_tready),
    .m_axis_tdata_o  (res_tdata),
    .m_axis_tlast_o  (res_tlast)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // result side: check on handshake, then draw the next stall
  always @(posedge clk_i) begin
    if (rst_n && res_tvalid && res_tready)
      tracker.check_result(res_tdata[2:0], res_tdata[18:3], res_tlast);
    res_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_cmd(input logic [2:0] op, input rde_pkg::elem_t val);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_tvalid <= 1'b1;
    cmd_tdata  <= {5'b0, val, op};
    @(posedge clk_i);
    while (!cmd_tready) @(posedge clk_i);
    tracker.note_command(op, val);
  endtask

  task automatic random_traffic(input int unsigned n);
    int unsigned pick;
    logic [2:0]  op;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 3)       op = rde_pkg::OP_CLEAR;
      else if (pick < 48) op = rde_pkg::OP_APPEND;
      else if (pick < 60) op = rde_pkg::OP_REV;
      else if (pick < 72) op = rde_pkg::OP_DELETE;
      else if (pick < 95) op = rde_pkg::OP_READ;
      else                op = 3'($urandom_range(7, 5));
      send_cmd(op, rde_pkg::elem_t'($urandom));
    end
  endtask

  initial begin
    int unsigned guard;
    tracker = new();
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed opening
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_cmd(rde_pkg::OP_READ,   '0);
    send_cmd(rde_pkg::OP_APPEND, 16'h8000);
    send_cmd(rde_pkg::OP_APPEND, 16'h7FFF);
    send_cmd(rde_pkg::OP_APPEND, 16'h0000);
    send_cmd(rde_pkg::OP_APPEND, 16'hFFFF);
    send_cmd(rde_pkg::OP_READ,   16'hFFFF);
    send_cmd(rde_pkg::OP_REV,    '0);
    send_cmd(rde_pkg::OP_READ,   '0);
    send_cmd(rde_pkg::OP_DELETE, '0);
    send_cmd(rde_pkg::OP_READ,   '0);
    send_cmd(rde_pkg::OP_DELETE, '0);
    send_cmd(rde_pkg::OP_REV,    '0);
    send_cmd(rde_pkg::OP_READ,   '0);
    send_cmd(rde_pkg::OP_DELETE, '0);
    send_cmd(rde_pkg::OP_APPEND, 16'h5555);
    send_cmd(3'd5,               16'hAAAA);
    send_cmd(3'd6,               16'hFFFF);
    send_cmd(3'd7,               16'h5555);
    send_cmd(rde_pkg::OP_CLEAR,  16'hFFFF);
    send_cmd(rde_pkg::OP_REV,    '0);
    send_cmd(rde_pkg::OP_APPEND, 16'hAAAA);
    send_cmd(rde_pkg::OP_APPEND, 16'h1234);
    send_cmd(rde_pkg::OP_READ,   '0);
    send_cmd(rde_pkg::OP_READ,   '0);
    send_cmd(rde_pkg::OP_READ,   '0);

    send_idle_pct = 6;
    recv_idle_pct = 88;
    random_traffic(325);
    send_idle_pct = 88;
    recv_idle_pct = 6;
    random_traffic(325);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(325);
    cmd_tvalid <= 1'b0;

    guard = 0;
    while (tracker.outstanding() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);
    if (tracker.outstanding() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, tracker.outstanding());
      tracker.failures++;
    end

    if (tracker.failures == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/rde_pkg.sv
rtl/core/reversible_deque_engine_unit.sv
test/tb.sv
